// ----- sv/rfc_pkg.sv -----
package rfc_pkg;

	// Largest transfer counted; bytes past it are dropped and the size saturates here.
	localparam int MAX_TRANSFER_BYTES = 1024;

	localparam int HEADER_BYTES    = 8;
	localparam int MIN_FRAME_BYTES = 9;

	localparam int BYTE_W = 8;
	localparam int HALF_W = 16;
	// Byte counter holds 0..MAX_TRANSFER_BYTES.
	localparam int POS_W  = $clog2(MAX_TRANSFER_BYTES + 1);
	// Sums of a 16-bit length and a small constant, also wide enough for the counter.
	localparam int SUM_W  = 17;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam int VERDICT_W = 3;
	localparam int OUT_DATA_W = 72;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_MARKER = 1'b0,
		CFG_END_MARKER   = 1'b1
	} cfg_index_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_VERDICT = 1'b1
	} item_kind_t;

	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_ACCEPTED    = 3'd0,
		VERDICT_TOO_SHORT   = 3'd1,
		VERDICT_BAD_START   = 3'd2,
		VERDICT_LEN_EXCEEDS = 3'd3,
		VERDICT_BAD_END     = 3'd4
	} verdict_t;

	// Marker values in force.
	typedef struct packed {
		logic [BYTE_W-1:0] start_marker;
		logic [BYTE_W-1:0] end_marker;
	} markers_t;

	// One classified word between front and back.
	typedef struct packed {
		item_kind_t        kind;
		logic [BYTE_W-1:0] data;
		logic [BYTE_W-1:0] token;
		logic [HALF_W-1:0] command;
		logic [HALF_W-1:0] length;
		logic [BYTE_W-1:0] ret;
		logic [BYTE_W-1:0] flags;
		logic              too_short;
		logic              start_ok;
		logic              len_exceeds;
		logic              end_ok;
	} entry_t;

endpackage

// ----- sv/rfc_front.sv -----
module rfc_front import rfc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  markers_t          markers,
	input  logic              in_valid,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              in_last,
	input  logic              q_full,
	output logic              in_ready,
	output logic              push,
	output entry_t            push_entry
);

	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] token_q;
	logic [HALF_W-1:0] command_q;
	logic [HALF_W-1:0] length_q;
	logic [BYTE_W-1:0] return_q;
	logic [BYTE_W-1:0] flags_q;
	logic              start_ok_q;
	logic              end_ok_q;

	logic [POS_W-1:0]  pos_n;
	logic [BYTE_W-1:0] token_n;
	logic [HALF_W-1:0] command_n;
	logic [HALF_W-1:0] length_n;
	logic [BYTE_W-1:0] return_n;
	logic [BYTE_W-1:0] flags_n;
	logic              start_ok_n;
	logic              end_ok_n;

	logic              accept;
	logic              active;
	logic              is_payload;
	logic [SUM_W-1:0]  pos_ext;
	logic [SUM_W-1:0]  end_pos;
	logic [SUM_W-1:0]  need_bytes;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign active   = pos_q < POS_W'(MAX_TRANSFER_BYTES);
	assign pos_ext  = SUM_W'(pos_q);
	assign end_pos  = SUM_W'(length_q) + SUM_W'(HEADER_BYTES);

	always_comb begin
		pos_n      = pos_q;
		token_n    = token_q;
		command_n  = command_q;
		length_n   = length_q;
		return_n   = return_q;
		flags_n    = flags_q;
		start_ok_n = start_ok_q;
		end_ok_n   = end_ok_q;
		is_payload = 1'b0;
		if (active) begin
			pos_n = pos_q + POS_W'(1);
			if (pos_q < POS_W'(HEADER_BYTES)) begin
				case (pos_q[2:0])
					3'd0: start_ok_n = (in_byte == markers.start_marker);
					3'd1: token_n = in_byte;
					3'd2: command_n = {command_q[HALF_W-1:BYTE_W], in_byte};
					3'd3: command_n = {in_byte, command_q[BYTE_W-1:0]};
					3'd4: length_n = {length_q[HALF_W-1:BYTE_W], in_byte};
					3'd5: length_n = {in_byte, length_q[BYTE_W-1:0]};
					3'd6: return_n = in_byte;
					3'd7: flags_n = in_byte;
					default: ;
				endcase
			end else if (pos_ext < end_pos) begin
				is_payload = 1'b1;
			end else if (pos_ext == end_pos) begin
				end_ok_n = (in_byte == markers.end_marker);
			end
		end
	end

	assign need_bytes = SUM_W'(length_n) + SUM_W'(MIN_FRAME_BYTES);

	always_comb begin
		push_entry.kind        = in_last ? KIND_VERDICT : KIND_PAYLOAD;
		push_entry.data        = in_byte;
		push_entry.token       = token_n;
		push_entry.command     = command_n;
		push_entry.length      = length_n;
		push_entry.ret         = return_n;
		push_entry.flags       = flags_n;
		push_entry.too_short   = pos_n < POS_W'(MIN_FRAME_BYTES);
		push_entry.start_ok    = start_ok_n;
		push_entry.len_exceeds = need_bytes > SUM_W'(pos_n);
		push_entry.end_ok      = end_ok_n;
	end

	assign push = accept && (in_last || is_payload);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			token_q    <= '0;
			command_q  <= '0;
			length_q   <= '0;
			return_q   <= '0;
			flags_q    <= '0;
			start_ok_q <= 1'b0;
			end_ok_q   <= 1'b0;
		end else if (accept) begin
			if (in_last) begin
				pos_q      <= '0;
				token_q    <= '0;
				command_q  <= '0;
				length_q   <= '0;
				return_q   <= '0;
				flags_q    <= '0;
				start_ok_q <= 1'b0;
				end_ok_q   <= 1'b0;
			end else begin
				pos_q      <= pos_n;
				token_q    <= token_n;
				command_q  <= command_n;
				length_q   <= length_n;
				return_q   <= return_n;
				flags_q    <= flags_n;
				start_ok_q <= start_ok_n;
				end_ok_q   <= end_ok_n;
			end
		end
	end

endmodule

// ----- sv/rfc_queue.sv -----
module rfc_queue import rfc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output logic   full,
	output logic   not_empty,
	output entry_t head
);

	entry_t     slots_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign head      = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- sv/rfc_back.sv -----
module rfc_back import rfc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_not_empty,
	input  entry_t                head,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data,
	output logic                  out_kind,
	output logic                  out_last
);

	logic                  valid_q;
	logic [OUT_DATA_W-1:0] data_q;
	logic                  kind_q;
	logic                  last_q;

	verdict_t              verdict;
	logic [OUT_DATA_W-1:0] data_n;

	assign pop = q_not_empty && (!valid_q || out_ready);

	// Checks in priority order.
	always_comb begin
		if (head.too_short) begin
			verdict = VERDICT_TOO_SHORT;
		end else if (!head.start_ok) begin
			verdict = VERDICT_BAD_START;
		end else if (head.len_exceeds) begin
			verdict = VERDICT_LEN_EXCEEDS;
		end else if (!head.end_ok) begin
			verdict = VERDICT_BAD_END;
		end else begin
			verdict = VERDICT_ACCEPTED;
		end
	end

	always_comb begin
		if (head.kind == KIND_VERDICT) begin
			data_n = {5'd0, verdict, head.flags, head.ret, head.length, head.command,
				head.token, 8'd0};
		end else begin
			data_n = {64'd0, head.data};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= data_n;
			kind_q <= head.kind;
			last_q <= head.kind == KIND_VERDICT;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_kind  = kind_q;
	assign out_last  = last_q;

endmodule

// ----- sv/response_frame_checker.sv -----
// Response frame checker.
// Input stream (s_axis): one received byte per word, tlast on the final byte
// of a transfer. Frame: start marker, token, command (LE16), payload length
// (LE16), return code, flags, payload, end marker.
// Output stream (m_axis): tuser = 0 is a forwarded payload byte; tuser = 1
// with tlast is the verdict of the transfer, carrying the header fields.
// Bytes that are neither payload nor final (header, end marker, trailing
// bytes, bytes past the saturated count) give no output word.
// Throughput: one input byte per cycle, sustained while the queue is not
// full. The front parser decides in the accepting cycle, the word sits in a
// two-entry queue and then in the output register that drives m_axis_tvalid.
// When m_axis_tready is held low the queue fills and s_axis_tready drops
// once it holds two words; nothing is lost or repeated.
// Reset (arst_n low): markers return to 0x5A / 0xA5, the frame state and the
// queue are emptied. cfg_we writes a marker (index 0 start, 1 end); the user
// must only use it while no transfer is in flight (not enforced by the block).
module response_frame_checker import rfc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] rx_byte
	input  logic                  s_axis_tlast,   // end_of_transfer
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [7:0] payload_byte, [15:8] frame_token, [31:16] command_code,
	// [47:32] payload_length, [55:48] ret_code, [63:56] frame_flags,
	// [66:64] verdict, [71:67] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tuser,   // item_kind
	output logic                  m_axis_tlast    // last_of_frame
);

	markers_t markers_q;
	logic     q_full;
	logic     q_not_empty;
	logic     push;
	logic     pop;
	entry_t   push_entry;
	entry_t   head;

	// Marker registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			markers_q.start_marker <= 8'd90;
			markers_q.end_marker   <= 8'd165;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_START_MARKER: markers_q.start_marker <= cfg_data;
				CFG_END_MARKER:   markers_q.end_marker   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front: header capture, payload/marker classification, verdict checks.
	rfc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.markers    (markers_q),
		.in_valid   (s_axis_tvalid),
		.in_byte    (s_axis_tdata),
		.in_last    (s_axis_tlast),
		.q_full     (q_full),
		.in_ready   (s_axis_tready),
		.push       (push),
		.push_entry (push_entry)
	);

	rfc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.not_empty  (q_not_empty),
		.head       (head)
	);

	// Back: verdict encoding, word formatting, output register.
	rfc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_data    (m_axis_tdata),
		.out_kind    (m_axis_tuser),
		.out_last    (m_axis_tlast)
	);

endmodule

// ----- test/response_frame_checker_test.sv -----
`timescale 1ns / 1ps

module response_frame_checker_test import rfc_pkg::*; ;

	// Clock, reset and block ports. Every input starts at a known value.
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_START_MARKER;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic                  s_valid = 1'b0;
	logic                  s_ready;
	logic [BYTE_W-1:0]     s_data = '0;
	logic                  s_last = 1'b0;

	logic                  m_valid;
	logic                  m_ready = 1'b0;
	logic [OUT_DATA_W-1:0] m_data;
	logic                  m_user;
	logic                  m_last;

	// One received byte waiting to go out on the input stream.
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} rx_word_t;

	// One predicted output word, field by field.
	typedef struct packed {
		item_kind_t        kind;
		logic [BYTE_W-1:0] payload;
		logic [BYTE_W-1:0] token;
		logic [HALF_W-1:0] command;
		logic [HALF_W-1:0] length;
		logic [BYTE_W-1:0] ret;
		logic [BYTE_W-1:0] flags;
		verdict_t          verdict;
		logic              last;
	} outcome_t;

	rx_word_t feed_q[$];     // bytes not yet offered
	outcome_t outcome_q[$];  // predicted words not yet seen
	int queued = 0;          // bytes put into feed_q so far
	int accepted = 0;        // bytes taken by the block so far
	int failures = 0;

	// Marker values currently in force, mirrored from the writes we make.
	logic [BYTE_W-1:0] start_mk = 8'h5A;
	logic [BYTE_W-1:0] end_mk   = 8'hA5;

	// Frame parser state, same layout as the block keeps it.
	logic [POS_W-1:0]  frm_pos = '0;
	logic [BYTE_W-1:0] frm_token = '0;
	logic [HALF_W-1:0] frm_cmd = '0;
	logic [HALF_W-1:0] frm_len = '0;
	logic [BYTE_W-1:0] frm_ret = '0;
	logic [BYTE_W-1:0] frm_flags = '0;
	logic              frm_start_ok = 1'b0;
	logic              frm_end_ok = 1'b0;

	bit feed_calm = 1'b0;   // stretch with no input gaps
	bit drain_calm = 1'b0;  // stretch with no output stalls
	int gap_left = 0;
	int hold_left = 0;

	response_frame_checker dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),    // [7:0] rx_byte
		.s_axis_tlast  (s_last),    // end_of_transfer
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		// [7:0] payload_byte, [15:8] frame_token, [31:16] command_code,
		// [47:32] payload_length, [55:48] ret_code, [63:56] frame_flags,
		// [66:64] verdict, [71:67] zero
		.m_axis_tdata  (m_data),
		.m_axis_tuser  (m_user),    // item_kind
		.m_axis_tlast  (m_last)     // last_of_frame
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	// Advance the frame parser by one accepted byte and queue the word it yields.
	task automatic parse_byte(input logic [BYTE_W-1:0] b, input logic last);
		int p;
		bit is_payload;
		verdict_t v;
		is_payload = 1'b0;
		if (frm_pos < MAX_TRANSFER_BYTES) begin
			p = int'(frm_pos);
			case (p)
				0: frm_start_ok = (b == start_mk);
				1: frm_token = b;
				2: frm_cmd[7:0] = b;
				3: frm_cmd[15:8] = b;
				4: frm_len[7:0] = b;
				5: frm_len[15:8] = b;
				6: frm_ret = b;
				7: frm_flags = b;
				default: begin
					if (p < HEADER_BYTES + frm_len)
						is_payload = 1'b1;
					else if (p == HEADER_BYTES + frm_len)
						frm_end_ok = (b == end_mk);
				end
			endcase
			frm_pos = frm_pos + 1'b1;
		end
		// Bytes past the saturated count are dropped; the size stays at the cap.

		if (!last) begin
			if (is_payload)
				outcome_q.push_back('{KIND_PAYLOAD, b, 8'h00, 16'h0000, 16'h0000,
					8'h00, 8'h00, VERDICT_ACCEPTED, 1'b0});
		end else begin
			// A final byte inside the payload gives the verdict alone.
			if (frm_pos < MIN_FRAME_BYTES)
				v = VERDICT_TOO_SHORT;
			else if (!frm_start_ok)
				v = VERDICT_BAD_START;
			else if (frm_len + MIN_FRAME_BYTES > frm_pos)
				v = VERDICT_LEN_EXCEEDS;
			else if (!frm_end_ok)
				v = VERDICT_BAD_END;
			else
				v = VERDICT_ACCEPTED;
			outcome_q.push_back('{KIND_VERDICT, 8'h00, frm_token, frm_cmd, frm_len,
				frm_ret, frm_flags, v, 1'b1});
			frm_pos = '0;
			frm_token = '0;
			frm_cmd = '0;
			frm_len = '0;
			frm_ret = '0;
			frm_flags = '0;
			frm_start_ok = 1'b0;
			frm_end_ok = 1'b0;
		end
	endtask

	// Queue the first count bytes of a frame; the last of them carries tlast.
	// Header bytes are random or all set to fill; the length field is len.
	task automatic queue_transfer(input logic [BYTE_W-1:0] first, input logic [HALF_W-1:0] len,
			input bit good_end, input int count, input bit rand_hdr = 1'b1,
			input logic [BYTE_W-1:0] fill = 8'h00);
		logic [BYTE_W-1:0] b;
		int p;
		for (p = 0; p < count; p++) begin
			b = rand_hdr ? 8'($urandom) : fill;
			if (p == 0)
				b = first;
			else if (p == 4)
				b = len[7:0];
			else if (p == 5)
				b = len[15:8];
			else if (p >= HEADER_BYTES && p < HEADER_BYTES + len)
				b = 8'($urandom);
			else if (p == HEADER_BYTES + len)
				b = good_end ? end_mk : end_mk ^ 8'($urandom_range(1, 255));
			else if (p > HEADER_BYTES + len)
				b = 8'($urandom);  // trailing, ignored by the block
			feed_q.push_back('{b, p == count - 1});
			queued++;
		end
	endtask

	// Idle once every byte is taken and every predicted word has come out.
	task automatic wait_drained(input int settle);
		while (accepted != queued || outcome_q.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Input side: predict on each accepted word, then offer the next one
	// after a random gap.
	always @(posedge clk) begin
		rx_word_t w;
		if (!arst_n) begin
			s_valid <= 1'b0;
			s_data <= '0;
			s_last <= 1'b0;
		end else begin
			if (s_valid && s_ready) begin
				parse_byte(s_data, s_last);
				accepted++;
			end
			if (!s_valid || s_ready) begin
				if ($urandom_range(0, 63) == 0)
					feed_calm = !feed_calm;
				if (gap_left > 0) begin
					gap_left--;
					s_valid <= 1'b0;
				end else if (feed_q.size() != 0) begin
					w = feed_q.pop_front();
					s_valid <= 1'b1;
					s_data <= w.data;
					s_last <= w.last;
					gap_left = pick_gap(feed_calm);
				end else begin
					s_valid <= 1'b0;
				end
			end
		end
	end

	// Output side: check each accepted word against the oldest prediction,
	// and stall tready at random.
	always @(posedge clk) begin
		outcome_t want;
		if (!arst_n) begin
			m_ready <= 1'b0;
		end else begin
			if (m_valid && m_ready) begin
				if (outcome_q.size() == 0) begin
					$error("unexpected output word: tdata %h tuser %b tlast %b",
						m_data, m_user, m_last);
					failures++;
				end else begin
					want = outcome_q.pop_front();
					if (m_user !== want.kind) begin
						$error("item_kind: expected %0d, got %0d", want.kind, m_user);
						failures++;
					end
					if (m_data[7:0] !== want.payload) begin
						$error("payload_byte: expected %0h, got %0h", want.payload, m_data[7:0]);
						failures++;
					end
					if (m_data[15:8] !== want.token) begin
						$error("frame_token: expected %0h, got %0h", want.token, m_data[15:8]);
						failures++;
					end
					if (m_data[31:16] !== want.command) begin
						$error("command_code: expected %0h, got %0h", want.command,
							m_data[31:16]);
						failures++;
					end
					if (m_data[47:32] !== want.length) begin
						$error("payload_length: expected %0h, got %0h", want.length,
							m_data[47:32]);
						failures++;
					end
					if (m_data[55:48] !== want.ret) begin
						$error("ret_code: expected %0h, got %0h", want.ret, m_data[55:48]);
						failures++;
					end
					if (m_data[63:56] !== want.flags) begin
						$error("frame_flags: expected %0h, got %0h", want.flags, m_data[63:56]);
						failures++;
					end
					if (m_data[66:64] !== want.verdict) begin
						$error("verdict: expected %0d, got %0d", want.verdict, m_data[66:64]);
						failures++;
					end
					if (m_last !== want.last) begin
						$error("last_of_frame: expected %0d, got %0d", want.last, m_last);
						failures++;
					end
				end
			end
			if ($urandom_range(0, 63) == 0)
				drain_calm = !drain_calm;
			if (hold_left > 0) begin
				hold_left--;
				m_ready <= 1'b0;
			end else begin
				m_ready <= 1'b1;
				hold_left = pick_gap(drain_calm);
			end
		end
	end

	// Stimulus: directed frames, then random phases under several marker pairs.
	initial begin
		logic [BYTE_W-1:0] phase_start[5];
		logic [BYTE_W-1:0] phase_end[5];
		logic [HALF_W-1:0] len;
		int phase;
		int phase_base;
		int trail;
		int r;

		phase_start = '{8'h5A, 8'h00, 8'hFF, 8'($urandom), 8'h00};
		phase_end   = '{8'hA5, 8'hFF, 8'h00, 8'($urandom), 8'h00};
		phase_end[4] = 8'($urandom);
		phase_start[4] = phase_end[4];  // both markers equal

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Single byte: too short, no header fields received yet.
		queue_transfer(start_mk, 16'h0000, 1'b1, 1);
		// Smallest good frame, token, command, return code and flags at all ones.
		queue_transfer(start_mk, 16'h0000, 1'b1, 9, 1'b0, 8'hFF);
		// Smallest frame with a wrong end marker, header at zero.
		queue_transfer(start_mk, 16'h0000, 1'b0, 9, 1'b0, 8'h00);
		// Largest length, transfer ends on the first payload byte.
		queue_transfer(start_mk, 16'hFFFF, 1'b1, 9);

		for (phase = 0; phase < 5; phase++) begin
			if (phase > 0) begin
				wait_drained(8);
				@(posedge clk);
				cfg_we <= 1'b1;
				cfg_index <= CFG_START_MARKER;
				cfg_data <= phase_start[phase];
				@(posedge clk);
				cfg_index <= CFG_END_MARKER;
				cfg_data <= phase_end[phase];
				@(posedge clk);
				cfg_we <= 1'b0;
				start_mk = phase_start[phase];
				end_mk = phase_end[phase];
			end

			phase_base = queued;
			while (queued - phase_base < 64) begin
				r = $urandom_range(0, 99);
				len = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(17, 60))
					: 16'($urandom_range(0, 16));
				trail = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
				if (r < 60) begin
					queue_transfer(start_mk, len, 1'b1, 9 + len + trail);
				end else if (r < 68) begin
					// Wrong start: payload still forwarded, verdict flags it.
					queue_transfer(start_mk ^ 8'($urandom_range(1, 255)), len, 1'b1,
						9 + len + trail);
				end else if (r < 76) begin
					queue_transfer(start_mk, len, 1'b0, 9 + len + trail);
				end else if (r < 84) begin
					// Transfer ends before the end marker position.
					len = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(1, 24));
					if (len == 0)
						len = 16'd1;
					queue_transfer(start_mk, len, 1'b1,
						$urandom_range(9, (8 + len < 40) ? 8 + len : 40));
				end else if (r < 92) begin
					queue_transfer(start_mk, 16'($urandom), 1'b1, $urandom_range(1, 8));
				end else begin
					queue_transfer(8'($urandom), 16'($urandom), 1'($urandom),
						$urandom_range(1, 24));
				end
			end

			if (phase == 4) begin
				// Byte count saturates: good frame whose end marker is the last
				// counted byte, with trailing bytes past the cap.
				queue_transfer(start_mk, 16'd1015, 1'b1, 1030);
			end
		end

		wait_drained(10);
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/rfc_pkg.sv
sv/rfc_front.sv
sv/rfc_queue.sv
sv/rfc_back.sv
sv/response_frame_checker.sv
test/response_frame_checker_test.sv
